@@ hw/rtl/lbr_pkg.sv @@
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared opcodes, status codes and a helper for the LSB-first bit reader.
// ----------------------------------------------------------------------------
package lbr_pkg;

   // Width of one read field and of one pushed byte
   localparam int FIELD_BITS = 32;
   localparam int BYTE_BITS  = 8;

   typedef enum logic [1:0] {
      OP_PUSH     = 2'd0,
      OP_READ     = 2'd1,
      OP_READ_REV = 2'd2,
      OP_ALIGN    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_SHORT = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Mirror a full field, bit 0 to bit FIELD_BITS-1
   function automatic logic [FIELD_BITS-1:0] reverse_field(input logic [FIELD_BITS-1:0] v);
      logic [FIELD_BITS-1:0] r;
      for (int i = 0; i < FIELD_BITS; i++) begin
         r[i] = v[FIELD_BITS-1-i];
      end
      return r;
   endfunction

endpackage

@@ hw/rtl/lsb_first_bit_reader.sv @@
// ----------------------------------------------------------------------------
// lsb_first_bit_reader: LSB-first bit reader with a bounded bit buffer
// Result is registered; one item per cycle unless the result stalls.
// Push shifts the byte in at the top; read and align shift bits down.
// Synchronous reset empties the buffer and clears the consumed-bit count.
// ----------------------------------------------------------------------------
module lsb_first_bit_reader
   import lbr_pkg::*;
#(
   parameter int BUFFER_BITS   = 64,
   parameter int MAX_READ_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_data_byte,
   input  logic [5:0]  req_bit_count,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_bits_held,
   output logic [31:0] rsp_bits_consumed
);

   // Held count is at least as wide as the bits_held port
   localparam int HeldWidth = ($clog2(BUFFER_BITS + 1) > 7) ? $clog2(BUFFER_BITS + 1) : 7;
   localparam int SumWidth  = HeldWidth + 1;

   // Buffer state; bits at and above held_ff are always zero
   logic [BUFFER_BITS-1:0] buffer_ff, buffer_in;
   logic [HeldWidth-1:0]   held_ff, held_in;
   logic [31:0]            consumed_ff, consumed_in;

   // Result register
   logic                   rsp_valid_ff;
   logic [FIELD_BITS-1:0]  value_ff, value_in;
   status_type             status_ff, status_in;

   logic                   accept;
   opcode_type             op;
   logic [5:0]             count;
   logic [5:0]             drop_n;
   logic [FIELD_BITS-1:0]  low_bits;
   logic [FIELD_BITS-1:0]  field_mask;
   logic [FIELD_BITS-1:0]  fwd_value;
   logic [FIELD_BITS-1:0]  rev_value;
   logic [5:0]             rev_shift;

   // Take a new item whenever the result register is free or drains now
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign op        = opcode_type'(req_opcode);

   // Saturate the read length
   assign count = (req_bit_count > 6'(MAX_READ_BITS)) ? 6'(MAX_READ_BITS) : req_bit_count;

   // Extract the field from the bottom of the buffer
   assign low_bits   = buffer_ff[FIELD_BITS-1:0];
   assign field_mask = ~({FIELD_BITS{1'b1}} << count);
   assign fwd_value  = low_bits & field_mask;
   assign rev_shift  = 6'(FIELD_BITS) - count;
   assign rev_value  = reverse_field(fwd_value) >> rev_shift;

   // Decode the item and form next state and result
   always_comb begin
      status_in = ST_OK;
      value_in  = '0;
      drop_n    = '0;
      buffer_in = buffer_ff;
      held_in   = held_ff;
      case (op)
         OP_PUSH: begin
            if (SumWidth'(held_ff) + SumWidth'(BYTE_BITS) > SumWidth'(BUFFER_BITS)) begin
               status_in = ST_FULL;
            end else begin
               buffer_in = buffer_ff | (BUFFER_BITS'(req_data_byte) << held_ff);
               held_in   = held_ff + HeldWidth'(BYTE_BITS);
            end
         end
         OP_READ, OP_READ_REV: begin
            if (SumWidth'(count) > SumWidth'(held_ff)) begin
               status_in = ST_SHORT;
            end else begin
               value_in = (op == OP_READ_REV) ? rev_value : fwd_value;
               drop_n   = count;
            end
         end
         OP_ALIGN: begin
            drop_n = {3'b000, held_ff[2:0]};
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
      // Drop consumed bits off the bottom
      if (op != OP_PUSH) begin
         buffer_in = buffer_ff >> drop_n;
         held_in   = held_ff - HeldWidth'(drop_n);
      end
      consumed_in = consumed_ff + 32'(drop_n);
   end

   // Advance buffer state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_ff    <= '0;
         held_ff      <= '0;
         consumed_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            buffer_ff   <= buffer_in;
            held_ff     <= held_in;
            consumed_ff <= consumed_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Hold the result payload until the next accepted item
   always_ff @(posedge clock) begin
      if (accept) begin
         value_ff  <= value_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_value         = value_ff;
   assign rsp_status        = status_ff;
   assign rsp_bits_held     = held_ff[6:0] & 7'h7F;
   assign rsp_bits_consumed = consumed_ff;

endmodule

@@ hw/rtl/lbr_checker.sv @@
// ----------------------------------------------------------------------------
// lbr_checker
// Port-level checks for the LSB-first bit reader, bound to the top level.
// ----------------------------------------------------------------------------
module lbr_checker
   import lbr_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_value,
   input logic [1:0]  rsp_status,
   input logic [6:0]  rsp_bits_held,
   input logic [31:0] rsp_bits_consumed
);

   // A stalled result holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_value) && $stable(rsp_status)
         && $stable(rsp_bits_held) && $stable(rsp_bits_consumed))
      else $error("stalled result changed");

   // Every accepted item shows its result on the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted item gave no result");

   // Request side stalls only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without a waiting result");

   // A refused or short item returns no data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_value == 32'd0)
      else $error("error result carries data");

   // Status is one of the defined codes
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_SHORT || rsp_status == ST_FULL)
      else $error("undefined status code");

endmodule

bind lsb_first_bit_reader lbr_checker u_lbr_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_value         (rsp_value),
   .rsp_status        (rsp_status),
   .rsp_bits_held     (rsp_bits_held),
   .rsp_bits_consumed (rsp_bits_consumed)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for lsb_first_bit_reader
// Drives pushes, plain and reversed reads and aligns over the valid/stall
// channels, predicts every result from a shadow bit buffer and compares each
// returned item field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
   import lbr_pkg::*;

   localparam int BUFFER_BITS   = 64;
   localparam int MAX_READ_BITS = 32;
   localparam int RANDOM_ITEMS  = 1800;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int LONG_HOLD     = 150;

   typedef struct {
      logic [31:0] value;
      status_type  status;
      logic [6:0]  held;
      logic [31:0] consumed;
   } reader_result_type;

   // Shadow bit buffer and queue of results still owed by the block
   class reader_scoreboard;
      logic [BUFFER_BITS-1:0] shadow_bits;
      int                     held;
      logic [31:0]            consumed;
      reader_result_type      owed[$];
      int                     fail_count;

      function new();
         shadow_bits = '0;
         held        = 0;
         consumed    = '0;
         fail_count  = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void flag(string msg);
         fail_count++;
         $error("%s", msg);
      endfunction

      // Advance the shadow buffer by one accepted item and queue its result
      function void note_request(opcode_type op, logic [7:0] data, logic [5:0] count);
         reader_result_type r;
         int n;
         r.value  = '0;
         r.status = ST_OK;
         case (op)
            OP_PUSH: begin
               if (held + BYTE_BITS > BUFFER_BITS) begin
                  r.status = ST_FULL;
               end else begin
                  shadow_bits = shadow_bits | (BUFFER_BITS'(data) << held);
                  held += BYTE_BITS;
               end
            end
            OP_READ, OP_READ_REV: begin
               n = (count > MAX_READ_BITS) ? MAX_READ_BITS : int'(count);
               if (n > held) begin
                  r.status = ST_SHORT;
               end else begin
                  for (int i = 0; i < n; i++) begin
                     if (shadow_bits[i]) r.value[(op == OP_READ_REV) ? n - 1 - i : i] = 1'b1;
                  end
                  shadow_bits = shadow_bits >> n;
                  held -= n;
                  consumed += 32'(n);
               end
            end
            default: begin
               // drop the tail of a partly used byte
               n = held % BYTE_BITS;
               shadow_bits = shadow_bits >> n;
               held -= n;
               consumed += 32'(n);
            end
         endcase
         r.held     = 7'(held);
         r.consumed = consumed;
         owed.push_back(r);
      endfunction

      // Compare one returned item with the oldest owed result
      function void check_response(logic [31:0] value, logic [1:0] status,
                                   logic [6:0] bits_held, logic [31:0] bits_consumed);
         reader_result_type e;
         if (owed.size() == 0) begin
            flag("result item arrived with nothing owed");
            return;
         end
         e = owed.pop_front();
         if (value !== e.value)
            flag($sformatf("value: expected %h, got %h", e.value, value));
         if (status !== e.status)
            flag($sformatf("status: expected %0d, got %0d", e.status, status));
         if (bits_held !== e.held)
            flag($sformatf("bits_held: expected %0d, got %0d", e.held, bits_held));
         if (bits_consumed !== e.consumed)
            flag($sformatf("bits_consumed: expected %0d, got %0d", e.consumed,
                           bits_consumed));
      endfunction
   endclass

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_stall;
   logic [1:0]  req_opcode    = '0;
   logic [7:0]  req_data_byte = '0;
   logic [5:0]  req_bit_count = '0;
   logic        rsp_valid;
   logic        rsp_stall     = 1'b0;
   logic [31:0] rsp_value;
   logic [1:0]  rsp_status;
   logic [6:0]  rsp_bits_held;
   logic [31:0] rsp_bits_consumed;

   bit          steady        = 1'b0;
   bit          hold_request  = 1'b0;
   int          cycle_count   = 0;

   reader_scoreboard sb = new();

   lsb_first_bit_reader #(
      .BUFFER_BITS   (BUFFER_BITS),
      .MAX_READ_BITS (MAX_READ_BITS)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_data_byte     (req_data_byte),
      .req_bit_count     (req_bit_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_value         (rsp_value),
      .rsp_status        (rsp_status),
      .rsp_bits_held     (rsp_bits_held),
      .rsp_bits_consumed (rsp_bits_consumed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(opcode_type op, logic [7:0] data, logic [5:0] count);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= data;
      req_bit_count <= count;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, data, count);
   endtask

   // Pick a random item, mostly a sensible stream that keeps the buffer fed
   task automatic send_stream_item();
      opcode_type op;
      logic [7:0] data;
      logic [5:0] count;
      int         sel;
      int         top;
      data  = 8'($urandom);
      count = 6'($urandom);
      sel   = $urandom_range(0, 99);
      if (sel < 8) begin
         op = opcode_type'($urandom_range(0, 3));
      end else if (sb.held <= BUFFER_BITS - BYTE_BITS &&
                   (sb.held < MAX_READ_BITS || $urandom_range(0, 1) == 1)) begin
         op = OP_PUSH;
      end else begin
         sel = $urandom_range(0, 9);
         if (sel == 0) op = OP_ALIGN;
         else if (sel <= 3) op = OP_READ_REV;
         else op = OP_READ;
         top = (sb.held < MAX_READ_BITS) ? sb.held : MAX_READ_BITS;
         count = 6'($urandom_range(1, top));
      end
      send_item(op, data, count);
   endtask

   // Receiver: stall at random per item, take long holds on request, check
   initial begin
      int n;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            n = steady ? 0 : $urandom_range(0, 3);
            if (n > 0) begin
               rsp_stall <= 1'b1;
               repeat (n) @(posedge clock);
               rsp_stall <= 1'b0;
            end
         end
         do @(posedge clock); while (!(rsp_valid === 1'b1 && !rsp_stall));
         sb.check_response(rsp_value, rsp_status, rsp_bits_held, rsp_bits_consumed);
      end
   end

   // Main sequence: reset, directed items, random stream, drain
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty buffer: short read, zero-bit read, align with nothing held
      send_item(OP_READ, 8'h00, 6'd5);
      send_item(OP_READ, 8'hFF, 6'd0);
      send_item(OP_READ_REV, 8'h00, 6'd0);
      send_item(OP_ALIGN, 8'h00, 6'd0);
      // fill to the brim, then a refused push
      send_item(OP_PUSH, 8'hFF, 6'd0);
      send_item(OP_PUSH, 8'h00, 6'd63);
      send_item(OP_PUSH, 8'hA5, 6'd0);
      send_item(OP_PUSH, 8'h5A, 6'd0);
      send_item(OP_PUSH, 8'h01, 6'd0);
      send_item(OP_PUSH, 8'h80, 6'd0);
      send_item(OP_PUSH, 8'h3C, 6'd0);
      send_item(OP_PUSH, 8'hC3, 6'd0);
      send_item(OP_PUSH, 8'h77, 6'd0);
      // oversized count saturates, single reversed bit, align mid-byte
      send_item(OP_READ, 8'h00, 6'd63);
      send_item(OP_READ_REV, 8'h00, 6'd1);
      send_item(OP_ALIGN, 8'hFF, 6'd63);
      send_item(OP_ALIGN, 8'h00, 6'd0);
      send_item(OP_READ_REV, 8'h00, 6'd32);
      send_item(OP_READ_REV, 8'h00, 6'd24);
      send_item(OP_PUSH, 8'hE7, 6'd0);
      send_item(OP_PUSH, 8'h19, 6'd0);
      send_item(OP_PUSH, 8'hF0, 6'd0);
      send_item(OP_PUSH, 8'h0F, 6'd0);
      send_item(OP_READ_REV, 8'h00, 6'd33);
      send_item(OP_READ, 8'h00, 6'd1);

      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         if (k == 500 || k == 1300) hold_request = 1'b1;
         if (k == 900) begin
            // withdraw the last item, then wait for every owed result
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         send_stream_item();
      end
      req_valid <= 1'b0;

      // drain, then allow for the block's latency
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (sb.fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
